// ===== hw/rtl/tcas_pkg.sv =====
// Package: slot count, widths, action codes and shared types of the alarm timer.
`timescale 1ns / 1ps
package tcas_pkg;

    localparam int SLOTS   = 4;
    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int COUNT_W = $clog2(SLOTS + 1);

    localparam logic [7:0] WINDOW_LEN = 8'hff;

    localparam logic ACT_TICK     = 1'b0;
    localparam logic ACT_REGISTER = 1'b1;

    // One item as it reaches the shared logic, with its strobe.
    typedef struct packed {
        logic        step;
        logic        action;
        logic        asleep;
        logic [31:0] deadline;
    } op_t;

    typedef struct packed {
        logic        action;
        logic        asleep;
        logic [31:0] deadline;
    } in_item_t;

    typedef struct packed {
        logic        registered;
        logic [1:0]  slot_index;
        logic [3:0]  fired_mask;
        logic [31:0] tick_count;
        logic [2:0]  active_count;
        logic        wake_valid;
        logic [7:0]  wake_count;
    } out_item_t;

endpackage

// ===== hw/rtl/tcas_in_if.sv =====
// Interface: input channel of the alarm timer (action, asleep, deadline).
`timescale 1ns / 1ps
interface tcas_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic        asleep;
    logic [31:0] deadline;

    modport source (output valid, output action, output asleep, output deadline, input ready);
    modport sink   (input valid, input action, input asleep, input deadline, output ready);
endinterface

// ===== hw/rtl/tcas_out_if.sv =====
// Interface: result channel of the alarm timer.
`timescale 1ns / 1ps
interface tcas_out_if;
    logic        valid;
    logic        ready;
    logic        registered;
    logic [1:0]  slot_index;
    logic [3:0]  fired_mask;
    logic [31:0] tick_count;
    logic [2:0]  active_count;
    logic        wake_valid;
    logic [7:0]  wake_count;

    modport source (output valid, output registered, output slot_index, output fired_mask,
                    output tick_count, output active_count, output wake_valid,
                    output wake_count, input ready);
    modport sink   (input valid, input registered, input slot_index, input fired_mask,
                    input tick_count, input active_count, input wake_valid,
                    input wake_count, output ready);
endinterface

// ===== hw/rtl/tcas_timer.sv =====
// Tick counter and the 255-tick wake window.
`timescale 1ns / 1ps
module tcas_timer (
    input  logic          clk,
    input  logic          rst_n,
    input  tcas_pkg::op_t op,
    output logic [31:0]   ticks_next,
    output logic          wake_valid,
    output logic [7:0]    wake_count
);
    import tcas_pkg::*;

    logic [31:0] ticks_reg;
    logic [7:0]  win_ticks_reg;
    logic [7:0]  win_asleep_reg;
    logic [7:0]  win_ticks_next;
    logic [7:0]  win_asleep_next;
    logic [7:0]  ticks_inc;
    logic [7:0]  asleep_inc;
    logic        is_tick;

    assign is_tick = (op.action == ACT_TICK);

    always_comb
    begin
        ticks_inc       = win_ticks_reg + 8'd1;
        asleep_inc      = win_asleep_reg + {7'd0, op.asleep};
        ticks_next      = ticks_reg;
        win_ticks_next  = win_ticks_reg;
        win_asleep_next = win_asleep_reg;
        wake_valid      = 1'b0;
        wake_count      = 8'd0;
        if (is_tick)
        begin
            ticks_next      = ticks_reg + 32'd1;
            win_ticks_next  = ticks_inc;
            win_asleep_next = asleep_inc;
            // Close the window: report awake ticks and restart
            if (ticks_inc == WINDOW_LEN)
            begin
                wake_valid      = 1'b1;
                wake_count      = WINDOW_LEN - asleep_inc;
                win_ticks_next  = 8'd0;
                win_asleep_next = 8'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg      <= 32'd0;
            win_ticks_reg  <= 8'd0;
            win_asleep_reg <= 8'd0;
        end
        else if (op.step)
        begin
            ticks_reg      <= ticks_next;
            win_ticks_reg  <= win_ticks_next;
            win_asleep_reg <= win_asleep_next;
        end
    end

endmodule

// ===== hw/rtl/tcas_slots.sv =====
// Alarm slot bank: allocation of the lowest free slot and firing against the count.
`timescale 1ns / 1ps
module tcas_slots (
    input  logic                           clk,
    input  logic                           rst_n,
    input  tcas_pkg::op_t                  op,
    input  logic [31:0]                    ticks_new,
    output logic                           registered,
    output logic [tcas_pkg::SLOT_W-1:0]    slot_idx,
    output logic [tcas_pkg::SLOTS-1:0]     fired,
    output logic [tcas_pkg::COUNT_W-1:0]   active
);
    import tcas_pkg::*;

    logic [SLOTS-1:0] busy_reg;
    logic [SLOTS-1:0] busy_next;
    logic [31:0]      deadline_reg [SLOTS];
    logic [SLOTS-1:0] alloc_onehot;

    always_comb
    begin
        registered   = 1'b0;
        slot_idx     = '0;
        alloc_onehot = '0;
        fired        = '0;
        busy_next    = busy_reg;
        if (op.action == ACT_REGISTER)
        begin
            // Scan from the top so the lowest free slot wins
            for (int i = SLOTS - 1; i >= 0; i--)
            begin
                if (!busy_reg[i])
                begin
                    registered   = 1'b1;
                    slot_idx     = SLOT_W'(i);
                    alloc_onehot = SLOTS'(1) << i;
                end
            end
            busy_next = busy_reg | alloc_onehot;
        end
        else
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                fired[i] = busy_reg[i] && (deadline_reg[i] < ticks_new);
            end
            busy_next = busy_reg & ~fired;
        end
    end

    always_comb
    begin
        active = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            active = active + COUNT_W'(busy_next[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= '0;
        end
        else if (op.step)
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            if (op.step && alloc_onehot[i])
            begin
                deadline_reg[i] <= op.deadline;
            end
        end
    end

endmodule

// ===== hw/rtl/tick_counter_with_alarm_slots_top.sv =====
// Top level of the alarm timer: input register, slot bank, timer and result register.
//
//  channel  dir  fields                                     accept
//  in_ch    in   action, asleep, deadline                   valid && ready
//  out_ch   out  registered, slot_index, fired_mask,        valid && ready
//                tick_count, active_count, wake_valid, wake_count
//
// One item per cycle while the result is not stalled; a beat moves from the input register
// to the result register when the result register is empty or being read.
// The slot compare and lowest-free search act on the input register each cycle.
// Reset clears the count, the window and all slot busy bits.
// A stalled result holds the input register; one more beat is taken only if it is empty.
`timescale 1ns / 1ps
module tick_counter_with_alarm_slots_top (
    input  logic         clk,
    input  logic         rst_n,
    tcas_in_if.sink      in_ch,
    tcas_out_if.source   out_ch
);
    import tcas_pkg::*;

    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    out_item_t out_item_next;
    logic      advance;
    op_t       op;

    logic [31:0]        ticks_next;
    logic               wake_valid;
    logic [7:0]         wake_count;
    logic               registered;
    logic [SLOT_W-1:0]  slot_idx;
    logic [SLOTS-1:0]   fired;
    logic [COUNT_W-1:0] active;
    logic [31:0]        slot_wide;
    logic [31:0]        fired_wide;
    logic [31:0]        active_wide;

    assign advance     = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = !in_valid_reg || advance;

    assign op.step     = in_valid_reg && advance;
    assign op.action   = in_item_reg.action;
    assign op.asleep   = in_item_reg.asleep;
    assign op.deadline = in_item_reg.deadline;

    tcas_timer u_timer (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (op),
        .ticks_next (ticks_next),
        .wake_valid (wake_valid),
        .wake_count (wake_count)
    );

    tcas_slots u_slots (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (op),
        .ticks_new  (ticks_next),
        .registered (registered),
        .slot_idx   (slot_idx),
        .fired      (fired),
        .active     (active)
    );

    // Fit the slot-sized values to the fixed result widths
    assign slot_wide   = 32'(slot_idx);
    assign fired_wide  = 32'(fired);
    assign active_wide = 32'(active);

    always_comb
    begin
        out_item_next.registered   = registered;
        out_item_next.slot_index   = slot_wide[1:0];
        out_item_next.fired_mask   = fired_wide[3:0];
        out_item_next.tick_count   = ticks_next;
        out_item_next.active_count = active_wide[2:0];
        out_item_next.wake_valid   = wake_valid;
        out_item_next.wake_count   = wake_count;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ch.ready)
            begin
                in_valid_reg <= in_ch.valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            in_item_reg.action   <= in_ch.action;
            in_item_reg.asleep   <= in_ch.asleep;
            in_item_reg.deadline <= in_ch.deadline;
        end
        if (op.step)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.registered   = out_item_reg.registered;
    assign out_ch.slot_index   = out_item_reg.slot_index;
    assign out_ch.fired_mask   = out_item_reg.fired_mask;
    assign out_ch.tick_count   = out_item_reg.tick_count;
    assign out_ch.active_count = out_item_reg.active_count;
    assign out_ch.wake_valid   = out_item_reg.wake_valid;
    assign out_ch.wake_count   = out_item_reg.wake_count;

endmodule
